// ===== sv/rdsc_pkg.sv =====
// ----------------------------------------------------------------------------
// rdsc_pkg: shared types and constants of the radix digit string converter
// Widths, register indexes, reset values, controller/datapath interface
// structs and the symbol table lookup.
// ----------------------------------------------------------------------------
package rdsc_pkg;

	// field widths
	localparam int VALUE_W  = 64;
	localparam int SYMBOL_W = 8;
	localparam int RADIX_W  = 5;
	localparam int DIGIT_W  = 4;
	localparam int CFG_IDX_W = 2;

	// largest base the symbol table covers
	localparam int MAX_RADIX = 16;

	// divider: bits retired per cycle, chunks per digit
	localparam int STEP_BITS = 8;
	localparam int CHUNKS    = VALUE_W / STEP_BITS;
	localparam int CHUNK_W   = $clog2(CHUNKS);

	// stored digit: digit value plus a "literal zero" marker bit on top
	localparam int ENTRY_W = DIGIT_W + 1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_RADIX        = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_LOW  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_HIGH = 2'd2;

	// reset values
	localparam logic [RADIX_W-1:0] RADIX_RESET        = 5'd10;
	localparam logic [VALUE_W-1:0] SYMBOLS_LOW_RESET  = 64'd3978425819141910832;
	localparam logic [VALUE_W-1:0] SYMBOLS_HIGH_RESET = 64'd280492157893177;

	// symbol emitted for a zero input, whatever the table holds
	localparam logic [SYMBOL_W-1:0] ZERO_SYMBOL = 8'h30;

	// controller -> datapath
	typedef struct packed {
		logic load;        // take a new value, clear digit count
		logic step;        // run one divider chunk
		logic last_chunk;  // this chunk finishes a digit
		logic issue;       // read the next digit for output
	} rdsc_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic quo_zero;    // quotient of the finishing digit is zero
		logic cnt_full;    // digit being finished takes the last free store entry
		logic last_addr;   // next read is the least significant digit
		logic can_issue;   // output side can take a read next cycle
	} rdsc_sts_t;

	// clamp the base register into 2..MAX_RADIX
	function automatic logic [RADIX_W-1:0] eff_base(input logic [RADIX_W-1:0] r);
		logic [RADIX_W-1:0] b;
		b = r;
		if (b < RADIX_W'(2))
			b = RADIX_W'(2);
		if (b > RADIX_W'(MAX_RADIX))
			b = RADIX_W'(MAX_RADIX);
		return b;
	endfunction

	// digit -> symbol byte through the two table registers
	function automatic logic [SYMBOL_W-1:0] symbol_of(
		input logic [VALUE_W-1:0] lo,
		input logic [VALUE_W-1:0] hi,
		input logic [DIGIT_W-1:0] d
	);
		logic [SYMBOL_W-1:0] s;
		if (d[DIGIT_W-1])
			s = hi[{d[DIGIT_W-2:0], 3'b000} +: SYMBOL_W];
		else
			s = lo[{d[DIGIT_W-2:0], 3'b000} +: SYMBOL_W];
		return s;
	endfunction

endpackage

// ===== sv/rdsc_ram.sv =====
// ----------------------------------------------------------------------------
// rdsc_ram: generic single write, single read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rdsc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re)
			rdata <= mem_q[raddr];
	end

endmodule

// ===== sv/rdsc_ctrl.sv =====
// ----------------------------------------------------------------------------
// rdsc_ctrl: converter controller
// Sequences one value: accept, repeated division chunk by chunk, then the
// reverse read-out of the stored digits.
// ----------------------------------------------------------------------------
module rdsc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  rdsc_pkg::rdsc_sts_t sts,
	output rdsc_pkg::rdsc_cmd_t cmd
);
	import rdsc_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_EMIT
	} state_t;

	state_t             state_q;
	logic [CHUNK_W-1:0] chunk_q;

	// commands
	always_comb begin
		cmd            = '0;
		cmd.load       = (state_q == ST_IDLE) && s_tvalid;
		cmd.step       = (state_q == ST_DIV);
		cmd.last_chunk = (state_q == ST_DIV) && (chunk_q == CHUNK_W'(CHUNKS - 1));
		cmd.issue      = (state_q == ST_EMIT) && sts.can_issue;
	end

	assign s_tready = (state_q == ST_IDLE);

	// state and chunk counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			chunk_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					chunk_q <= '0;
					if (s_tvalid)
						state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (cmd.last_chunk) begin
						chunk_q <= '0;
						if (sts.quo_zero || sts.cnt_full)
							state_q <= ST_EMIT;
					end else begin
						chunk_q <= chunk_q + CHUNK_W'(1);
					end
				end
				ST_EMIT: begin
					if (cmd.issue && sts.last_addr)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// reads only happen after the division has finished
	a_issue_in_emit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> !cmd.step)
		else $error("digit read issued during division");

	// a finished item always goes through read-out
	a_div_to_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && cmd.last_chunk && sts.quo_zero) |=> (state_q == ST_EMIT))
		else $error("division end did not start read-out");

	// leaving read-out only with the least significant digit
	a_emit_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && !cmd.issue) |=> (state_q == ST_EMIT))
		else $error("read-out left without issuing last digit");

endmodule

// ===== sv/rdsc_dp.sv =====
// ----------------------------------------------------------------------------
// rdsc_dp: converter datapath
// Chunked restoring divider by the base, digit store, reverse read-out
// and the output register with symbol lookup.
// ----------------------------------------------------------------------------
module rdsc_dp #(
	parameter int MAX_DIGITS = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  rdsc_pkg::rdsc_cmd_t               cmd,
	output rdsc_pkg::rdsc_sts_t               sts,
	input  logic [rdsc_pkg::VALUE_W-1:0]      value,
	input  logic [rdsc_pkg::RADIX_W-1:0]      base,
	input  logic [rdsc_pkg::VALUE_W-1:0]      symbols_low,
	input  logic [rdsc_pkg::VALUE_W-1:0]      symbols_high,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [rdsc_pkg::SYMBOL_W-1:0]     symbol,
	output logic                              last_digit
);
	import rdsc_pkg::*;

	localparam int AW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
	localparam int CW = $clog2(MAX_DIGITS + 1);

	logic [VALUE_W-1:0]   val_q;
	logic [DIGIT_W-1:0]   rem_q;
	logic                 zero_q;
	logic [CW-1:0]        cnt_q;
	logic [STEP_BITS-1:0] qbits;
	logic [DIGIT_W-1:0]   rem_next;
	logic [VALUE_W-1:0]   val_next;
	logic [ENTRY_W-1:0]   wr_entry;
	logic [ENTRY_W-1:0]   rd_entry;
	logic [AW-1:0]        rd_addr;
	logic                 rd_pend_s1;
	logic                 rd_last_s1;
	logic                 out_valid_q;
	logic [SYMBOL_W-1:0]  out_sym_q;
	logic                 out_last_q;

	// one divider chunk: STEP_BITS restoring steps on a narrow remainder
	always_comb begin
		logic [DIGIT_W:0] t;
		logic [DIGIT_W:0] r;
		r     = {1'b0, rem_q};
		qbits = '0;
		for (int i = 0; i < STEP_BITS; i++) begin
			t = {r[DIGIT_W-1:0], val_q[VALUE_W-1-i]};
			if (t >= base) begin
				t = t - base;
				qbits[STEP_BITS-1-i] = 1'b1;
			end
			r = t;
		end
		rem_next = r[DIGIT_W-1:0];
	end

	assign val_next = {val_q[VALUE_W-STEP_BITS-1:0], qbits};

	// divider registers and digit count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.load) begin
			cnt_q <= '0;
		end else if (cmd.step && cmd.last_chunk) begin
			cnt_q <= cnt_q + CW'(1);
		end else if (cmd.issue) begin
			cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			val_q  <= value;
			rem_q  <= '0;
			zero_q <= (value == '0);
		end else if (cmd.step) begin
			val_q <= val_next;
			rem_q <= cmd.last_chunk ? '0 : rem_next;
		end
	end

	// status
	assign sts.quo_zero  = (val_next == '0);
	assign sts.cnt_full  = ((cnt_q + CW'(1)) == CW'(MAX_DIGITS));
	assign sts.last_addr = (cnt_q == CW'(1));
	assign sts.can_issue = !rd_pend_s1 && (!out_valid_q || m_tready);

	// digit store
	assign wr_entry = {zero_q, rem_next};
	assign rd_addr  = AW'(cnt_q - CW'(1));

	rdsc_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_DIGITS)
	) u_ram (
		.clk  (clk),
		.we   (cmd.step && cmd.last_chunk),
		.waddr(cnt_q[AW-1:0]),
		.wdata(wr_entry),
		.re   (cmd.issue),
		.raddr(rd_addr),
		.rdata(rd_entry)
	);

	// read in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_pend_s1 <= 1'b0;
		end else begin
			rd_pend_s1 <= cmd.issue;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue)
			rd_last_s1 <= sts.last_addr;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rd_pend_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_pend_s1) begin
			out_sym_q  <= rd_entry[DIGIT_W] ? ZERO_SYMBOL
				: symbol_of(symbols_low, symbols_high, rd_entry[DIGIT_W-1:0]);
			out_last_q <= rd_last_s1;
		end
	end

	assign m_tvalid   = out_valid_q;
	assign symbol     = out_sym_q;
	assign last_digit = out_last_q;

	// returning read data always finds the output register free
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_s1 |-> !out_valid_q)
		else $error("read data arrived with output register full");

	// never read an empty digit store
	a_issue_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> (cnt_q != '0))
		else $error("digit read with empty store");

	// the digit written is a true remainder
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && cmd.last_chunk) |-> ({1'b0, rem_next} < base))
		else $error("remainder not below base");

endmodule

// ===== sv/radix_digit_string_converter_unit.sv =====
// Division: a value of n digits is divided one digit at a time, chunk by chunk
// (8 bits per cycle); read-out of the stored digits starts once division ends.
// Read-out: a new digit read waits until the previous read has left the RAM; the next
// value is accepted once the last digit's read is issued (n up to 64); symbol stalls hold it.
// Reset: config registers return to base 10 and the default table, controller
// idle, output empty; the digit RAM needs no clearing pass.
// ----------------------------------------------------------------------------
// radix_digit_string_converter_unit: binary to digit string converter
// Converts a 64-bit unsigned value into symbol bytes in a configured base,
// most significant digit first, flagging the least significant digit.
// ----------------------------------------------------------------------------
module radix_digit_string_converter_unit #(
	parameter int MAX_DIGITS = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// input value stream
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [rdsc_pkg::VALUE_W-1:0]       s_tdata,  // [63:0] value
	// symbol stream
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [rdsc_pkg::SYMBOL_W-1:0]      m_tdata,  // [7:0] symbol
	output logic                               m_tlast,  // last_digit
	// configuration writes
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [rdsc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rdsc_pkg::VALUE_W-1:0]       cfg_data
);
	import rdsc_pkg::*;

	logic [RADIX_W-1:0] radix_q;
	logic [VALUE_W-1:0] sym_lo_q;
	logic [VALUE_W-1:0] sym_hi_q;
	logic [RADIX_W-1:0] base;
	rdsc_cmd_t          cmd;
	rdsc_sts_t          sts;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q  <= RADIX_RESET;
			sym_lo_q <= SYMBOLS_LOW_RESET;
			sym_hi_q <= SYMBOLS_HIGH_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_RADIX:        radix_q  <= cfg_data[RADIX_W-1:0];
				REG_SYMBOLS_LOW:  sym_lo_q <= cfg_data;
				REG_SYMBOLS_HIGH: sym_hi_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign base = eff_base(radix_q);

	rdsc_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	rdsc_dp #(
		.MAX_DIGITS(MAX_DIGITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.value       (s_tdata),
		.base        (base),
		.symbols_low (sym_lo_q),
		.symbols_high(sym_hi_q),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.symbol      (m_tdata),
		.last_digit  (m_tlast)
	);

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: radix digit string converter unit
// Streams 64-bit values into the converter under a series of base and symbol
// table settings. Expected digit symbols are derived by repeated division in
// a scoreboard and compared with every symbol transaction, in order.
// ----------------------------------------------------------------------------
module testbench;
	import rdsc_pkg::*;

	localparam int HALF_PERIOD = 6;
	localparam int NUM_DIGITS  = 64;
	localparam int PHASE_ITEMS = 20;
	localparam int NUM_PHASES  = 8;
	localparam int HOLD_CYCLES = 1500;
	localparam int DRAIN_WAIT  = 20;
	localparam int BREAK_PCT   = 17;

	// index with no register behind it
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	// one expected symbol transaction
	typedef struct packed {
		logic [SYMBOL_W-1:0] symbol;
		logic                last_digit;
	} digit_t;

	// ------------------------------------------------------------------------
	// scoreboard: mirrors the registers, predicts digit symbols per value
	// ------------------------------------------------------------------------
	class digit_scoreboard;
		logic [RADIX_W-1:0] radix;
		logic [VALUE_W-1:0] sym_lo;
		logic [VALUE_W-1:0] sym_hi;
		digit_t             expected_q[$];
		int unsigned        mismatches;

		function new();
			radix      = 5'd10;
			sym_lo     = 64'd3978425819141910832;
			sym_hi     = 64'd280492157893177;
			mismatches = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [VALUE_W-1:0] data);
			case (idx)
			REG_RADIX: begin
				radix = data[RADIX_W-1:0];
			end
			REG_SYMBOLS_LOW: begin
				sym_lo = data;
			end
			REG_SYMBOLS_HIGH: begin
				sym_hi = data;
			end
			default: begin
			end
			endcase
		endfunction

		// divide down to zero, then queue the symbols most significant first
		function void note_value(logic [VALUE_W-1:0] value);
			logic [VALUE_W-1:0]   rest;
			logic [VALUE_W-1:0]   base;
			logic [2*VALUE_W-1:0] lut;
			logic [DIGIT_W-1:0]   digits[$];
			digit_t               d;
			rest = value;
			base = VALUE_W'(radix);
			if (base < 2)
				base = 2;
			if (base > MAX_RADIX)
				base = MAX_RADIX;
			lut = {sym_hi, sym_lo};
			// zero ignores the table
			if (value == 0) begin
				d.symbol     = ZERO_SYMBOL;
				d.last_digit = 1'b1;
				expected_q.push_back(d);
				return;
			end
			// keep only the least significant digits if there are too many
			while (rest != 0 && digits.size() < NUM_DIGITS) begin
				digits.push_front(DIGIT_W'(rest % base));
				rest = rest / base;
			end
			foreach (digits[k]) begin
				d.symbol     = lut[SYMBOL_W*int'(digits[k]) +: SYMBOL_W];
				d.last_digit = (k == digits.size() - 1);
				expected_q.push_back(d);
			end
		endfunction

		task report(string msg);
			$display("mismatch @%0t: %s", $time, msg);
			mismatches++;
		endtask

		task check_symbol(logic [SYMBOL_W-1:0] symbol, logic last_digit);
			digit_t want;
			if (expected_q.size() == 0) begin
				report($sformatf("symbol %h last %b with nothing pending", symbol, last_digit));
				return;
			end
			want = expected_q.pop_front();
			if (symbol !== want.symbol)
				report($sformatf("symbol %h, want %h", symbol, want.symbol));
			if (last_digit !== want.last_digit)
				report($sformatf("last %b, want %b", last_digit, want.last_digit));
		endtask

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [VALUE_W-1:0]   s_tdata   = '0;   // [63:0] value
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [SYMBOL_W-1:0]  m_tdata;          // [7:0] symbol
	logic                 m_tlast;          // last_digit
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [VALUE_W-1:0]   cfg_data  = '0;

	// no random breaks on either side while set
	bit calm     = 1'b0;
	// asks the symbol side for one long hold-off
	bit hold_req = 1'b0;

	digit_scoreboard sb = new();

	radix_digit_string_converter_unit #(
		.MAX_DIGITS(NUM_DIGITS)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #HALF_PERIOD clk = ~clk;

	function automatic bit take_break();
		return !calm && ($urandom_range(99) < BREAK_PCT);
	endfunction

	function automatic logic [VALUE_W-1:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// random value, mostly of random bit length
	function automatic logic [VALUE_W-1:0] rand_value();
		logic [VALUE_W-1:0] v;
		int unsigned        w;
		v = rand64();
		w = $urandom_range(VALUE_W, 1);
		case ($urandom_range(9))
		0: begin
			v = '0;
		end
		1: begin
			v = '1;
		end
		default: begin
			if (w < VALUE_W)
				v &= (VALUE_W'(1) << w) - 1;
		end
		endcase
		return v;
	endfunction

	// one value transaction; valid stays up for a following value
	task automatic send_value(input logic [VALUE_W-1:0] value);
		while (take_break()) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= value;
		do @(posedge clk); while (!s_tready);
		sb.note_value(value);
	endtask

	// one register write transaction; caller lowers cfg_valid
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VALUE_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
	endtask

	// base goes in the low bits, junk above them must be dropped
	task automatic configure(
		input logic [RADIX_W-1:0] radix,
		input logic [VALUE_W-1:0] lo,
		input logic [VALUE_W-1:0] hi
	);
		write_reg(REG_RADIX, (rand64() & ~VALUE_W'(5'h1F)) | VALUE_W'(radix));
		write_reg(REG_SYMBOLS_LOW, lo);
		write_reg(REG_SYMBOLS_HIGH, hi);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	// symbol side: check each transaction, then pick next ready
	initial begin : symbol_sink
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				sb.check_symbol(m_tdata, m_tlast);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= !take_break();
			end
		end
	end

	// stimulus: directed values, then random phases under new settings
	initial begin : stimulus
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: base 10, default table
		send_value(64'd0);
		send_value(64'd1);
		send_value(64'd9);
		send_value(64'd10);
		send_value('1);
		send_value(64'h8000_0000_0000_0000);

		// base 16
		wait_drained();
		configure(5'd16, rand64(), rand64());
		send_value(64'd0);
		send_value(64'h0123_4567_89AB_CDEF);
		send_value(64'hFEDC_BA98_7654_3210);
		send_value(64'd15);

		// base 2: full-width value gives the most digits
		wait_drained();
		configure(5'd2, rand64(), rand64());
		send_value(64'd0);
		send_value(64'd1);
		send_value('1);
		send_value(64'h8000_0000_0000_0000);

		// base register below two acts as base 2
		wait_drained();
		configure(5'd0, rand64(), rand64());
		send_value(64'd5);
		send_value('1);
		wait_drained();
		configure(5'd1, rand64(), rand64());
		send_value(64'd6);

		// base register above sixteen acts as base 16
		wait_drained();
		configure(5'd17, rand64(), rand64());
		send_value(64'd255);
		send_value(64'h1234_5678_9ABC_DEF0);
		wait_drained();
		configure(5'd31, rand64(), rand64());
		send_value(64'hFFFF);

		// write to an unused index is dropped
		wait_drained();
		write_reg(REG_UNUSED, 64'd3);
		cfg_valid <= 1'b0;
		send_value(64'd100);

		for (int p = 0; p < NUM_PHASES; p++) begin
			wait_drained();
			case (p)
			0: begin
				configure(5'd2, rand64(), rand64());
			end
			1: begin
				configure(5'd16, '0, '1);
			end
			2: begin
				configure(5'd10, '1, '0);
			end
			3: begin
				configure(5'd3, rand64(), rand64());
			end
			default: begin
				configure(RADIX_W'($urandom_range(MAX_RADIX, 2)), rand64(), rand64());
			end
			endcase
			// long stall on the symbol side while values keep coming
			if (p == 2)
				hold_req = 1'b1;
			calm = (p == 4);
			repeat (PHASE_ITEMS)
				send_value(rand_value());
		end

		wait_drained();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (sb.mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// hard stop if the run hangs
	initial begin : watchdog
		#30_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== radix_digit_string_converter_unit.f =====
sv/rdsc_pkg.sv
sv/rdsc_ram.sv
sv/rdsc_ctrl.sv
sv/rdsc_dp.sv
sv/radix_digit_string_converter_unit.sv
tb/sv/testbench.sv
